// ----- rtl/lgre_pkg.sv -----
// Shared types and constants for the life generation row engine.
`default_nettype none
package lgre_pkg;

    localparam int ROW_WIDTH   = 64;
    localparam int WIDTH_W     = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(ROW_WIDTH);

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Bits of one column that a cell shows to its neighbours.
    typedef struct packed {
        logic above;
        logic middle;
        logic below;
    } t_col_bits;

    // One result item.
    typedef struct packed {
        logic [ROW_WIDTH-1:0] cells;
        logic                 frame_done;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/life_generation_row_engine.sv -----
// Top level of the row-streamed B3/S23 life generation engine.
//
// Rows of a frame arrive one item per cycle and a new row is taken every cycle
// while the result queue has room for two items. Each row but a frame's first
// gives the next generation of the row before it; a frame's last row also gives
// its own result, so it pushes two items (one if it is the frame's only row).
// The engine is a row of column cells, which hold the two previous rows and
// work out every column of both possible results in the accepting cycle, and
// a four-entry result queue that drains one item per cycle when not stalled.
`default_nettype none
module life_generation_row_engine (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [lgre_pkg::WIDTH_W-1:0]        i_cfg_wdata,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [lgre_pkg::ROW_WIDTH-1:0]      i_row_cells,
    input  wire                                 i_last_row,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [lgre_pkg::ROW_WIDTH-1:0]      o_next_row_cells,
    output logic                                o_frame_done
);

    logic [lgre_pkg::WIDTH_W-1:0]   r_width;
    logic                           r_frame_open;
    logic                           n_frame_open;
    logic                           w_accept;
    logic                           w_room;
    logic [lgre_pkg::ROW_WIDTH-1:0] w_mask;
    logic [lgre_pkg::ROW_WIDTH-1:0] w_in_row;
    logic [lgre_pkg::ROW_WIDTH-1:0] w_res_middle;
    logic [lgre_pkg::ROW_WIDTH-1:0] w_res_in;
    lgre_pkg::t_col_bits            w_col [lgre_pkg::ROW_WIDTH];
    lgre_pkg::t_result              w_res_a;
    lgre_pkg::t_result              w_res_b;
    lgre_pkg::t_result              w_push0_data;
    lgre_pkg::t_result              w_q_data;
    logic                           w_push0;
    logic                           w_push1;

    assign o_in_stall = !w_room;
    assign w_accept   = i_in_valid & w_room;
    assign w_in_row   = i_row_cells & w_mask;

    genvar g;
    generate
        for (g = 0; g < lgre_pkg::ROW_WIDTH; g++) begin : g_col
            lgre_pkg::t_col_bits w_left;
            lgre_pkg::t_col_bits w_right;

            assign w_mask[g] = (r_width > lgre_pkg::WIDTH_W'(g));

            // Beyond either edge of the row every cell is dead.
            if (g == 0) begin : g_left_edge
                assign w_left = '0;
            end else begin : g_left_nbr
                assign w_left = w_col[g-1];
            end
            if (g == lgre_pkg::ROW_WIDTH - 1) begin : g_right_edge
                assign w_right = '0;
            end else begin : g_right_nbr
                assign w_right = w_col[g+1];
            end

            lgre_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (w_accept),
                .i_last       (i_last_row),
                .i_in_bit     (w_in_row[g]),
                .i_mask       (w_mask[g]),
                .i_left       (w_left),
                .i_right      (w_right),
                .o_col        (w_col[g]),
                .o_res_middle (w_res_middle[g]),
                .o_res_in     (w_res_in[g])
            );
        end
    endgenerate

    assign w_res_a.cells      = w_res_middle;
    assign w_res_a.frame_done = 1'b0;
    assign w_res_b.cells      = w_res_in;
    assign w_res_b.frame_done = 1'b1;

    // A one-row frame gives only the result for the arriving row.
    assign w_push0      = w_accept & (r_frame_open | i_last_row);
    assign w_push1      = w_accept & r_frame_open & i_last_row;
    assign w_push0_data = r_frame_open ? w_res_a : w_res_b;

    lgre_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_data0 (w_push0_data),
        .i_push1 (w_push1),
        .i_data1 (w_res_b),
        .i_pop   (!i_out_stall),
        .o_data  (w_q_data),
        .o_valid (o_out_valid),
        .o_room  (w_room)
    );

    assign o_next_row_cells = w_q_data.cells;
    assign o_frame_done     = w_q_data.frame_done;

    always_comb begin
        n_frame_open = r_frame_open;
        if (w_accept) begin
            n_frame_open = !i_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= lgre_pkg::WIDTH_RESET;
            r_frame_open <= 1'b0;
        end else begin
            r_frame_open <= n_frame_open;
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lgre_cell.sv -----
// One column cell: holds two rows of its column and applies the B3/S23 rule.
`default_nettype none
module lgre_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_load,
    input  wire                       i_last,
    input  wire                       i_in_bit,
    input  wire                       i_mask,
    input  wire lgre_pkg::t_col_bits  i_left,
    input  wire lgre_pkg::t_col_bits  i_right,
    output lgre_pkg::t_col_bits       o_col,
    output logic                      o_res_middle,
    output logic                      o_res_in
);

    logic       r_above;
    logic       r_middle;
    logic       n_above;
    logic       n_middle;
    logic [3:0] w_cnt_mid;
    logic [3:0] w_cnt_in;

    assign o_col.above  = r_above;
    assign o_col.middle = r_middle;
    assign o_col.below  = i_in_bit;

    // Neighbour counts leave the centre cell out.
    assign w_cnt_mid = 4'(i_left.above) + 4'(r_above) + 4'(i_right.above)
                     + 4'(i_left.middle) + 4'(i_right.middle)
                     + 4'(i_left.below) + 4'(i_in_bit) + 4'(i_right.below);

    // The arriving row on the frame's last item has a dead row below it.
    assign w_cnt_in  = 4'(i_left.middle) + 4'(r_middle) + 4'(i_right.middle)
                     + 4'(i_left.below) + 4'(i_right.below);

    assign o_res_middle = i_mask & ((w_cnt_mid == lgre_pkg::BIRTH_COUNT)
                        | (r_middle & (w_cnt_mid == lgre_pkg::SURVIVE_COUNT)));
    assign o_res_in     = i_mask & ((w_cnt_in == lgre_pkg::BIRTH_COUNT)
                        | (i_in_bit & (w_cnt_in == lgre_pkg::SURVIVE_COUNT)));

    always_comb begin
        n_above  = r_above;
        n_middle = r_middle;
        if (i_load) begin
            if (i_last) begin
                n_above  = 1'b0;
                n_middle = 1'b0;
            end else begin
                n_above  = r_middle;
                n_middle = i_in_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above  <= 1'b0;
            r_middle <= 1'b0;
        end else begin
            r_above  <= n_above;
            r_middle <= n_middle;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lgre_out_queue.sv -----
// Small result queue that takes up to two result items a cycle.
`default_nettype none
module lgre_out_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push0,
    input  wire lgre_pkg::t_result  i_data0,
    input  wire                     i_push1,
    input  wire lgre_pkg::t_result  i_data1,
    input  wire                     i_pop,
    output lgre_pkg::t_result       o_data,
    output logic                    o_valid,
    output logic                    o_room
);

    lgre_pkg::t_result                r_data [lgre_pkg::QUEUE_DEPTH];
    logic [lgre_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [lgre_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [lgre_pkg::QCNT_W-1:0]      r_count;
    logic [lgre_pkg::QPTR_W-1:0]      n_wr_ptr;
    logic [lgre_pkg::QPTR_W-1:0]      n_rd_ptr;
    logic [lgre_pkg::QCNT_W-1:0]      n_count;
    logic [lgre_pkg::QPTR_W-1:0]      w_wr_next;
    logic                             w_pop;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_data[r_rd_ptr];
    // Room for two items even if nothing leaves this cycle.
    assign o_room    = (r_count <= lgre_pkg::QCNT_W'(lgre_pkg::QUEUE_DEPTH - 2));
    assign w_pop     = i_pop & o_valid;
    assign w_wr_next = r_wr_ptr + lgre_pkg::QPTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + lgre_pkg::QPTR_W'(i_push0) + lgre_pkg::QPTR_W'(i_push1);
        n_rd_ptr = r_rd_ptr + lgre_pkg::QPTR_W'(w_pop);
        n_count  = r_count + lgre_pkg::QCNT_W'(i_push0) + lgre_pkg::QCNT_W'(i_push1)
                 - lgre_pkg::QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_data[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_data[w_wr_next] <= i_data1;
        end
    end

endmodule
`default_nettype wire
